// ===== hw/rtl/ddo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pkg
// types and constants shared by the odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

  typedef struct packed {
    logic               func;
    logic signed [15:0] left_pulses;
    logic signed [15:0] right_pulses;
    logic signed [47:0] load_x;
    logic signed [47:0] load_y;
    logic [31:0]        load_heading;
  } ddo_in_t;

  typedef struct packed {
    logic signed [47:0] pose_x;
    logic signed [47:0] pose_y;
    logic [31:0]        pose_heading;
  } ddo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULD,
    ST_MULA,
    ST_ANGLE,
    ST_CORDIC,
    ST_MULT,
    ST_POSE,
    ST_DONE
  } ddo_state_t;

  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  localparam logic [0:0] CFG_MM_PER_PULSE = 1'b0;
  localparam logic [0:0] CFG_ANGLE_PER_MM = 1'b1;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  function automatic logic [31:0] atan_bau(input logic [4:0] i);
    case (i)
      5'd0: atan_bau = 32'd536870912;
      5'd1: atan_bau = 32'd316933406;
      5'd2: atan_bau = 32'd167458907;
      5'd3: atan_bau = 32'd85004756;
      5'd4: atan_bau = 32'd42667331;
      5'd5: atan_bau = 32'd21354465;
      5'd6: atan_bau = 32'd10679838;
      5'd7: atan_bau = 32'd5340245;
      5'd8: atan_bau = 32'd2670163;
      5'd9: atan_bau = 32'd1335087;
      5'd10: atan_bau = 32'd667544;
      5'd11: atan_bau = 32'd333772;
      5'd12: atan_bau = 32'd166886;
      5'd13: atan_bau = 32'd83443;
      5'd14: atan_bau = 32'd41722;
      5'd15: atan_bau = 32'd20861;
      5'd16: atan_bau = 32'd10430;
      5'd17: atan_bau = 32'd5215;
      5'd18: atan_bau = 32'd2608;
      5'd19: atan_bau = 32'd1304;
      5'd20: atan_bau = 32'd652;
      5'd21: atan_bau = 32'd326;
      5'd22: atan_bau = 32'd163;
      5'd23: atan_bau = 32'd81;
      5'd24: atan_bau = 32'd41;
      5'd25: atan_bau = 32'd20;
      5'd26: atan_bau = 32'd10;
      5'd27: atan_bau = 32'd5;
      5'd28: atan_bau = 32'd3;
      5'd29: atan_bau = 32'd1;
      5'd30: atan_bau = 32'd1;
      default: atan_bau = 32'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/differential_drive_odometry.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry
// dead-reckoning pose integrator with a bit-serial arithmetic core
// ----------------------------------------------------------------------------
// sequence: an update beat runs the bit-serial wheel products, the bit-serial
//   heading product, the mid heading, the cordic at one iteration per cycle,
//   the bit-serial travel products and the pose sums, then holds its result;
//   a load beat writes the pose on accept and goes straight to the result
// throughput: one beat in flight, next beat taken the cycle after the result
//   is accepted
// reset: synchronous active-low, pose and config registers clear to zero
// ----------------------------------------------------------------------------
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ddo_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ddo_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [5:0] LAST_IT = 6'(CORDIC_STEPS - 1);

  ddo_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  logic [31:0] mpp_r, apm_r;
  logic [47:0] px_r, py_r;
  logic [31:0] hd_r;

  // wheel products: {partial sum, multiplier bits}, shifted right once per cycle
  logic [16:0] psum_r;   // l + r
  logic [16:0] pdif_r;   // r - l
  logic [49:0] ms_r;     // sum * mm_per_pulse
  logic [49:0] md_r;     // diff * mm_per_pulse
  logic [39:0] travel_r; // q.16 mm

  // diff (q.24) * angle_per_mm, same serial scheme
  logic [48:0] dq_r;
  logic [81:0] ma_r;
  logic [31:0] dth_r;

  // cordic
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;

  // travel * sin and travel * cos, multiplier is the signed trig value
  logic [40:0] tm_r;     // travel, negated when the angle was folded
  logic [75:0] mx_r, my_r;

  // helpers for the serial datapath
  logic [17:0]        hs_sum, hd_sum;
  logic [49:0]        ms_nxt, md_nxt;
  logic [49:0]        ha_sum;
  logic [81:0]        ma_nxt;
  logic [31:0]        mid;
  logic               flip;
  logic [31:0]        ang;
  logic signed [33:0] sh_x, sh_y;
  logic [31:0]        atv;
  logic signed [33:0] cx_nxt, cy_nxt;
  logic signed [32:0] cz_nxt;
  logic [41:0]        tm_ext, tm_add;
  logic [41:0]        hx_sum, hy_sum;
  logic [75:0]        mx_nxt, my_nxt;
  logic [47:0]        dx_mag, dy_w;

  assign out_data  = {px_r, py_r, hd_r};
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          state_nxt = (in_data.func == FUNC_LOAD) ? ST_DONE : ST_MULD;
        end
      end
      ST_MULD: begin
        if (cnt_r == 6'd31) begin
          state_nxt = ST_MULA;
          cnt_nxt   = '0;
        end
      end
      ST_MULA: begin
        if (cnt_r == 6'd31) begin
          state_nxt = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        state_nxt = ST_CORDIC;
        cnt_nxt   = '0;
      end
      ST_CORDIC: begin
        if (cnt_r == LAST_IT) begin
          state_nxt = ST_MULT;
          cnt_nxt   = '0;
        end
      end
      ST_MULT: begin
        if (cnt_r == 6'd33) begin
          state_nxt = ST_POSE;
        end
      end
      ST_POSE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // one multiplier bit per cycle, partial sum shifts right arithmetically
    hs_sum = ms_r[49:32] + (ms_r[0] ? {psum_r[16], psum_r} : 18'd0);
    hd_sum = md_r[49:32] + (md_r[0] ? {pdif_r[16], pdif_r} : 18'd0);
    ms_nxt = {hs_sum[17], hs_sum, ms_r[31:1]};
    md_nxt = {hd_sum[17], hd_sum, md_r[31:1]};
    ha_sum = ma_r[81:32] + (ma_r[0] ? {dq_r[48], dq_r} : 50'd0);
    ma_nxt = {ha_sum[49], ha_sum, ma_r[31:1]};
    // mid-step heading, folded into the right half-plane for the cordic
    mid  = hd_r + ma_r[72:41];
    flip = mid[31] ^ mid[30];
    ang  = {mid[31] ^ flip, mid[30:0]};
    sh_x = cx_r >>> cnt_r;
    sh_y = cy_r >>> cnt_r;
    atv  = atan_bau(cnt_r[4:0]);
    if (!cz_r[32]) begin
      cx_nxt = cx_r - sh_y;
      cy_nxt = cy_r + sh_x;
      cz_nxt = cz_r - {1'b0, atv};
    end else begin
      cx_nxt = cx_r + sh_y;
      cy_nxt = cy_r - sh_x;
      cz_nxt = cz_r + {1'b0, atv};
    end
    // top trig bit has negative weight
    tm_ext = {tm_r[40], tm_r};
    tm_add = (cnt_r == 6'd33) ? (42'd0 - tm_ext) : tm_ext;
    hx_sum = mx_r[75:34] + (mx_r[0] ? tm_add : 42'd0);
    hy_sum = my_r[75:34] + (my_r[0] ? tm_add : 42'd0);
    mx_nxt = {hx_sum[41], hx_sum, mx_r[33:1]};
    my_nxt = {hy_sum[41], hy_sum, my_r[33:1]};
    // floor(product / 2^30) in q.16 mm
    dx_mag = {{2{mx_r[75]}}, mx_r[75:30]};
    dy_w   = {{2{my_r[75]}}, my_r[75:30]};
  end

  // config and pose registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpp_r <= '0;
      apm_r <= '0;
      px_r  <= '0;
      py_r  <= '0;
      hd_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MM_PER_PULSE: mpp_r <= cfg_data;
          CFG_ANGLE_PER_MM: apm_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid && in_data.func == FUNC_LOAD) begin
        px_r <= in_data.load_x;
        py_r <= in_data.load_y;
        hd_r <= in_data.load_heading;
      end else if (state_r == ST_POSE) begin
        // x moves by -sin, y by cos
        px_r <= px_r - dx_mag;
        py_r <= py_r + dy_w;
        hd_r <= hd_r + dth_r;
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        psum_r <= {in_data.left_pulses[15], in_data.left_pulses}
                + {in_data.right_pulses[15], in_data.right_pulses};
        pdif_r <= {in_data.right_pulses[15], in_data.right_pulses}
                - {in_data.left_pulses[15], in_data.left_pulses};
        ms_r   <= {18'd0, mpp_r};
        md_r   <= {18'd0, mpp_r};
      end
      ST_MULD: begin
        ms_r <= ms_nxt;
        md_r <= md_nxt;
        if (cnt_r == 6'd31) begin
          travel_r <= ms_nxt[48:9];
          dq_r     <= md_nxt[48:0];
          ma_r     <= {50'd0, apm_r};
        end
      end
      ST_MULA: begin
        ma_r <= ma_nxt;
      end
      ST_ANGLE: begin
        cx_r  <= CORDIC_GAIN;
        cy_r  <= '0;
        cz_r  <= {ang[31], ang};
        tm_r  <= flip ? (41'd0 - {travel_r[39], travel_r}) : {travel_r[39], travel_r};
        dth_r <= ma_r[71:40];
      end
      ST_CORDIC: begin
        cx_r <= cx_nxt;
        cy_r <= cy_nxt;
        cz_r <= cz_nxt;
        // last load holds the final sine and cosine
        mx_r <= {42'd0, cy_nxt};
        my_r <= {42'd0, cx_nxt};
      end
      ST_MULT: begin
        mx_r <= mx_nxt;
        my_r <= my_nxt;
      end
      default: ;
    endcase
  end

endmodule

// ===== sim/differential_drive_odometry_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_drive_odometry_test
// Self-checking bench for the odometry pose integrator. A local dead-reckoning
// model with its own cordic predicts every pose beat. Beats are sent in random
// bursts while the result side stalls at times. Both config registers are swept
// through several settings between phases, including their extremes.
// ----------------------------------------------------------------------------
module differential_drive_odometry_test;
  import ddo_pkg::*;

  localparam int TRIG_STEPS = 24;

  // arctangent of 2^-i in binary angle units
  localparam longint ARCTAN_BAU [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ddo_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ddo_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  differential_drive_odometry dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of registers and pose
  logic [31:0] mdl_mm_per_pulse = '0;
  logic [31:0] mdl_angle_per_mm = '0;
  logic [47:0] mdl_x = '0;
  logic [47:0] mdl_y = '0;
  logic [31:0] mdl_heading = '0;

  ddo_in_t  beats_to_send [$];
  ddo_out_t poses_due [$];
  int errors = 0;
  int n_updates = 0;
  int n_loads = 0;
  int n_checked = 0;

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("mismatch %s at %0t: got %h want %h", what, $realtime, got, want);
    errors++;
  endtask

  // floor(v * t / 2^30), split so the products stay inside 64 bits
  function automatic longint scale_q30(input longint v, input longint t);
    longint hi, lo;
    hi = v >>> 20;
    lo = v & 64'hF_FFFF;
    return (hi * t + ((lo * t) >>> 20)) >>> 10;
  endfunction

  // rotation-mode cordic, q2.30 sine and cosine
  task automatic trig_of(input logic [31:0] ang, output longint s, output longint c);
    logic flip;
    longint x, y, z, nx;
    flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
    if (flip) ang[31] = ~ang[31];
    x = CORDIC_GAIN;
    y = 0;
    z = longint'(signed'(ang));
    for (int i = 0; i < TRIG_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ARCTAN_BAU[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ARCTAN_BAU[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endtask

  // advance the local pose by one accepted beat, queue the pose it gives
  task automatic integrate_pose(input ddo_in_t b);
    longint dl, dr, travel, diff, t, s, c, dx, dy;
    longint unsigned dlo;
    logic [31:0] mid;
    ddo_out_t p;
    if (b.func == FUNC_LOAD) begin
      mdl_x = b.load_x;
      mdl_y = b.load_y;
      mdl_heading = b.load_heading;
      n_loads++;
    end else begin
      dl = longint'(b.left_pulses) * longint'(mdl_mm_per_pulse);
      dr = longint'(b.right_pulses) * longint'(mdl_mm_per_pulse);
      travel = (dl + dr) >>> 9;
      diff = dr - dl;
      dlo = diff & 64'hFF_FFFF;
      t = (diff >>> 24) * longint'(mdl_angle_per_mm)
          + longint'((dlo * longint'(mdl_angle_per_mm)) >> 24);
      mid = mdl_heading + t[48:17];
      trig_of(mid, s, c);
      dx = -scale_q30(travel, s);
      dy = scale_q30(travel, c);
      mdl_x = mdl_x + dx[47:0];
      mdl_y = mdl_y + dy[47:0];
      mdl_heading = mdl_heading + t[47:16];
      n_updates++;
    end
    p.pose_x = mdl_x;
    p.pose_y = mdl_y;
    p.pose_heading = mdl_heading;
    poses_due.push_back(p);
  endtask

  // sender: random bursts separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) integrate_pose(in_data);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          in_data <= beats_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            // sometimes a long burst with no gaps at all
            burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            gap_left <= $urandom_range(0, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: picks a new stall mode whenever its mode counter runs out
  int stall_mode = 0;
  int mode_cycles = 0;
  int hold_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (poses_due.size() == 0) begin
          report_mismatch("unexpected pose beat", out_data.pose_x, '0);
        end else begin
          ddo_out_t want;
          want = poses_due.pop_front();
          if (out_data.pose_x !== want.pose_x)
            report_mismatch("pose_x", out_data.pose_x, want.pose_x);
          if (out_data.pose_y !== want.pose_y)
            report_mismatch("pose_y", out_data.pose_y, want.pose_y);
          if (out_data.pose_heading !== want.pose_heading)
            report_mismatch("pose_heading", {16'h0, out_data.pose_heading},
                            {16'h0, want.pose_heading});
          n_checked++;
        end
      end
      if (mode_cycles == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_cycles <= $urandom_range(100, 400);
      end else begin
        mode_cycles <= mode_cycles - 1;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: begin
            // long stretches of stall or ready
            out_ready <= ~out_ready;
            hold_cycles <= $urandom_range(0, 30);
          end
        endcase
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == CFG_MM_PER_PULSE) mdl_mm_per_pulse = value;
    else mdl_angle_per_mm = value;
  endtask

  task automatic drain;
    wait (beats_to_send.size() == 0 && !in_valid && poses_due.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic ddo_in_t make_beat(input logic f, input logic [15:0] l,
                                        input logic [15:0] r, input logic [47:0] x,
                                        input logic [47:0] y, input logic [31:0] h);
    ddo_in_t b;
    b.func = f;
    b.left_pulses = l;
    b.right_pulses = r;
    b.load_x = x;
    b.load_y = y;
    b.load_heading = h;
    return b;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [15:0] rand_pulses();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // mostly updates with random deltas, some loads
  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        beats_to_send.push_back(make_beat(FUNC_LOAD, 16'($urandom), 16'($urandom),
                                          rand48(), rand48(), $urandom));
      else
        beats_to_send.push_back(make_beat(FUNC_UPDATE, rand_pulses(), rand_pulses(),
                                          rand48(), rand48(), $urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset value: updates must leave the pose alone
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h7FFF, 16'h8000, '1, '1, '1));
    drain();

    // unit scales, directed corners
    write_reg(CFG_MM_PER_PULSE, 32'h0100_0000);
    write_reg(CFG_ANGLE_PER_MM, 32'h0001_0000);
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h7FFF, 16'h7FFF, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h8000, 16'h8000, '1, '1, '1));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h8000, 16'h7FFF, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h7FFF, 16'h8000, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h0000, 16'h0000, '0, '0, '0));
    // loads at field extremes and quadrant edges of the heading
    beats_to_send.push_back(make_beat(FUNC_LOAD, 16'hFFFF, 16'hFFFF,
                                      48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, '1));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'd100, 16'd100, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, '0, '0, 32'h4000_0000));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'd50, 16'd50, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, '0, '0, 32'h8000_0000));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'd50, 16'd50, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, '0, '0, 32'hC000_0000));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'd50, 16'd50, '0, '0, '0));
    // heading wraps past one turn
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, '0, '0, 32'hFFFF_FF00));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h8000, 16'h7FFF, '0, '0, '0));
    // position wraps in both directions
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, 48'h8000_0000_0010,
                                      48'h7FFF_FFFF_FFF0, 32'h4000_0000));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h7FFF, 16'h7FFF, '0, '0, '0));
    beats_to_send.push_back(make_beat(FUNC_LOAD, '0, '0, '0, 48'h7FFF_FFFF_FFF0, '0));
    beats_to_send.push_back(make_beat(FUNC_UPDATE, 16'h7FFF, 16'h7FFF, '0, '0, '0));
    queue_random(250);
    drain();

    // both registers at full scale
    write_reg(CFG_MM_PER_PULSE, 32'hFFFF_FFFF);
    write_reg(CFG_ANGLE_PER_MM, 32'hFFFF_FFFF);
    queue_random(250);
    drain();

    // random settings, the last with tiny scales
    for (int k = 0; k < 4; k++) begin
      write_reg(CFG_MM_PER_PULSE, k == 3 ? $urandom_range(0, 255) : $urandom);
      write_reg(CFG_ANGLE_PER_MM, k == 3 ? $urandom_range(0, 255) : $urandom);
      queue_random(225);
      drain();
    end

    $display("covered %0d updates and %0d loads over seven register settings",
             n_updates, n_loads);
    $display("%0d pose beats compared, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d poses outstanding", poses_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
